// ===== hdl/ptp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared widths, codes, payload types and saturation helpers for the
// point-to-point move stepper.
// ----------------------------------------------------------------------------
package ptp_pkg;

    // coordinate format
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;

    // field widths
    localparam int SPEED_W   = 31;
    localparam int DELTA_W   = 20;
    localparam int SCALE_W   = COORD_W - 1;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;

    // tick datapath widths
    localparam int MAG_W  = COORD_W + 1;        // |target - position|
    localparam int STEP_W = COORD_W + 1;        // saturated step length
    localparam int PROD_W = SPEED_W + DELTA_W;  // speed * delta
    localparam int ACC_W  = 2 * MAG_W + 2;      // squares, products, root remainder

    // request modes
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLACE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CENTRE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [MAG_W-1:0]          mag_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [DELTA_W-1:0] delta;
        coord_t             new_x;
        coord_t             new_y;
    } ptp_req_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        coord_t center_x;
        coord_t center_y;
        logic   at_target;
    } ptp_res_t;

    // tick unit operands
    typedef struct packed {
        mag_t               ax;
        mag_t               ay;
        logic [DELTA_W-1:0] delta;
    } ptp_tick_op_t;

    // tick unit status and results
    typedef struct packed {
        logic done;
        logic snap;
        mag_t qx;
        mag_t qy;
    } ptp_tick_res_t;

    // clip a one-bit-wider signed value to the coordinate range
    function automatic coord_t sat_coord(input logic signed [COORD_W:0] v);
        coord_t r;
        if (v[COORD_W] != v[COORD_W-1])
        begin
            r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // floor(scale / 2), extended to the one-bit-wider signed range
    function automatic logic signed [COORD_W:0] half_ext(input logic [SCALE_W-1:0] s);
        return {{(COORD_W + 2 - SCALE_W){1'b0}}, s[SCALE_W-1:1]};
    endfunction

endpackage

// ===== hdl/ptp_tick_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_tick_unit
// Sequenced tick arithmetic around one shared add/subtract unit: step length,
// squared distance, snap compare, integer square root and the two
// per-axis multiply/divide pairs, one bit per cycle.
// ----------------------------------------------------------------------------
module ptp_tick_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  ptp_pkg::ptp_tick_op_t         op,
    input  logic [ptp_pkg::SPEED_W-1:0]   speed,
    output ptp_pkg::ptp_tick_res_t        res
);
    import ptp_pkg::*;

    localparam int ROOT_STEPS = ACC_W / 2;
    localparam int CNT_W      = $clog2(ROOT_STEPS);

    localparam logic [CNT_W-1:0] DELTA_LAST = CNT_W'(DELTA_W - 1);
    localparam logic [CNT_W-1:0] MAG_LAST   = CNT_W'(MAG_W - 1);
    localparam logic [CNT_W-1:0] STEP_LAST  = CNT_W'(STEP_W - 1);
    localparam logic [CNT_W-1:0] ROOT_LAST  = CNT_W'(ROOT_STEPS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_STEP = 4'd1;
    localparam logic [3:0] S_SQX  = 4'd2;
    localparam logic [3:0] S_SQY  = 4'd3;
    localparam logic [3:0] S_SQS  = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_ROOT = 4'd6;
    localparam logic [3:0] S_MULX = 4'd7;
    localparam logic [3:0] S_DIVX = 4'd8;
    localparam logic [3:0] S_MULY = 4'd9;
    localparam logic [3:0] S_DIVY = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0]            state_reg,  state_next;
    logic [CNT_W-1:0]      cnt_reg,    cnt_next;
    logic [ACC_W-1:0]      acc_reg,    acc_next;
    logic [ACC_W-1:0]      mcand_reg,  mcand_next;
    logic [MAG_W-1:0]      mplier_reg, mplier_next;
    logic [ACC_W-1:0]      d2_reg,     d2_next;
    logic [ROOT_STEPS-1:0] root_reg,   root_next;
    logic [STEP_W-1:0]     step_reg,   step_next;
    mag_t                  ax_reg,     ax_next;
    mag_t                  ay_reg,     ay_next;
    mag_t                  qx_reg,     qx_next;
    mag_t                  qy_reg,     qy_next;
    logic                  snap_reg,   snap_next;

    // shared unit
    logic [ACC_W-1:0] alu_a;
    logic [ACC_W-1:0] alu_b;
    logic             alu_sub;
    logic [ACC_W:0]   alu_full;
    logic [ACC_W-1:0] alu_sum;
    logic             alu_ge;
    logic             last;
    mag_t             quot;

    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg) inside
            S_STEP, S_SQX, S_SQY, S_SQS, S_MULX, S_MULY:
            begin
                alu_b = mplier_reg[0] ? mcand_reg : '0;
            end
            S_CMP:
            begin
                // squared distance against squared step
                alu_a   = d2_reg;
                alu_b   = acc_reg;
                alu_sub = 1'b1;
            end
            S_ROOT:
            begin
                alu_a   = {acc_reg[ACC_W-3:0], d2_reg[ACC_W-1:ACC_W-2]};
                alu_b   = ACC_W'({root_reg, 2'b01});
                alu_sub = 1'b1;
            end
            S_DIVX, S_DIVY:
            begin
                alu_a   = {acc_reg[ACC_W-2:0], mplier_reg[MAG_W-1]};
                alu_b   = ACC_W'(root_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_b = '0;
            end
        endcase
        alu_full = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + (ACC_W + 1)'(alu_sub);
        alu_sum  = alu_full[ACC_W-1:0];
        alu_ge   = alu_full[ACC_W];
    end

    assign last = (cnt_reg == '0);
    assign quot = {mplier_reg[MAG_W-2:0], alu_ge};

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        d2_next     = d2_reg;
        root_next   = root_reg;
        step_next   = step_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        qx_next     = qx_reg;
        qy_next     = qy_reg;
        snap_next   = snap_reg;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (start)
                begin
                    ax_next     = op.ax;
                    ay_next     = op.ay;
                    acc_next    = '0;
                    mcand_next  = ACC_W'(speed);
                    mplier_next = MAG_W'(op.delta);
                    cnt_next    = DELTA_LAST;
                    state_next  = S_STEP;
                end
            end
            S_STEP, S_SQX, S_SQY, S_SQS, S_MULX, S_MULY:
            begin
                acc_next    = alu_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (last)
                begin
                    if (state_reg == S_STEP)
                    begin
                        // floor(speed * delta), clipped to the step range
                        step_next = (|alu_sum[PROD_W-1:FRAC_BITS+STEP_W]) ? '1
                                  : alu_sum[FRAC_BITS+STEP_W-1:FRAC_BITS];
                        acc_next    = '0;
                        mcand_next  = ACC_W'(ax_reg);
                        mplier_next = ax_reg;
                        cnt_next    = MAG_LAST;
                        state_next  = S_SQX;
                    end
                    else if (state_reg == S_SQX)
                    begin
                        // keep the sum, add ay squared on top
                        mcand_next  = ACC_W'(ay_reg);
                        mplier_next = ay_reg;
                        cnt_next    = MAG_LAST;
                        state_next  = S_SQY;
                    end
                    else if (state_reg == S_SQY)
                    begin
                        d2_next     = alu_sum;
                        acc_next    = '0;
                        mcand_next  = ACC_W'(step_reg);
                        mplier_next = MAG_W'(step_reg);
                        cnt_next    = STEP_LAST;
                        state_next  = S_SQS;
                    end
                    else if (state_reg == S_SQS)
                    begin
                        state_next = S_CMP;
                    end
                    else
                    begin
                        // quotient fits in MAG_W bits, so start with the upper part
                        acc_next    = alu_sum >> MAG_W;
                        mplier_next = alu_sum[MAG_W-1:0];
                        cnt_next    = MAG_LAST;
                        state_next  = (state_reg == S_MULX) ? S_DIVX : S_DIVY;
                    end
                end
            end
            S_CMP:
            begin
                if (!alu_ge)
                begin
                    snap_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    snap_next  = 1'b0;
                    acc_next   = '0;
                    root_next  = '0;
                    cnt_next   = ROOT_LAST;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                acc_next  = alu_ge ? alu_sum : alu_a;
                root_next = {root_reg[ROOT_STEPS-2:0], alu_ge};
                d2_next   = d2_reg << 2;
                cnt_next  = cnt_reg - 1'b1;
                if (last)
                begin
                    acc_next    = '0;
                    mcand_next  = ACC_W'(ax_reg);
                    mplier_next = MAG_W'(step_reg);
                    cnt_next    = STEP_LAST;
                    state_next  = S_MULX;
                end
            end
            S_DIVX, S_DIVY:
            begin
                acc_next    = alu_ge ? alu_sum : alu_a;
                mplier_next = quot;
                cnt_next    = cnt_reg - 1'b1;
                if (last)
                begin
                    if (state_reg == S_DIVX)
                    begin
                        qx_next     = (quot > ax_reg) ? ax_reg : quot;
                        acc_next    = '0;
                        mcand_next  = ACC_W'(ay_reg);
                        mplier_next = MAG_W'(step_reg);
                        cnt_next    = STEP_LAST;
                        state_next  = S_MULY;
                    end
                    else
                    begin
                        qy_next    = (quot > ay_reg) ? ay_reg : quot;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        d2_reg     <= d2_next;
        root_reg   <= root_next;
        step_reg   <= step_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        snap_reg   <= snap_next;
    end

    assign res.done = (state_reg == S_DONE);
    assign res.snap = snap_reg;
    assign res.qx   = qx_reg;
    assign res.qy   = qy_reg;

endmodule

// ===== hdl/point_to_point_move_stepper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_point_move_stepper
// Holds a 2D Q16.16 position and moves it toward a programmed target at
// constant speed; place requests set the position directly or by view centre.
// ----------------------------------------------------------------------------
// every request returns one result: position, view centre (position plus half
// the view scale, clipped) and an at-target flag. a tick request moves the
// position by speed*delta along the line to the target, or lands on the target
// when it is closer than that. one request is handled at a time and req_stall
// stays high until its result sits in the output register. tick requests run
// on a bit-serial add/subtract unit: speed*delta, three squares, square root
// and two multiply/divide pairs for a move, stopping after the compare when
// the position lands on the target; a tick already on the target, place
// requests and unused mode codes do not use the unit. a finished result
// waits in the output register while the next request is taken. registers
// are written through the cfg channel, always ready, and are meant to change
// only while the block is idle.
// ----------------------------------------------------------------------------
module point_to_point_move_stepper (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ptp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptp_pkg::COORD_W-1:0]     cfg_data,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  ptp_pkg::ptp_req_t               req,
    output logic                            res_valid,
    input  logic                            res_stall,
    output ptp_pkg::ptp_res_t               res
);
    import ptp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;  // distance to target registered
    localparam logic [1:0] ST_TICK = 2'd2;  // tick unit running
    localparam logic [1:0] ST_DONE = 2'd3;  // result waits for the output register

    // configuration
    logic [SPEED_W-1:0] speed_reg,    speed_next;
    coord_t             target_x_reg, target_x_next;
    coord_t             target_y_reg, target_y_next;
    logic [SCALE_W-1:0] scale_x_reg,  scale_x_next;
    logic [SCALE_W-1:0] scale_y_reg,  scale_y_next;

    // position and control
    logic [1:0]             state_reg, state_next;
    coord_t                 cur_x_reg, cur_x_next;
    coord_t                 cur_y_reg, cur_y_next;
    logic signed [COORD_W:0] dx_reg,   dx_next;
    logic signed [COORD_W:0] dy_reg,   dy_next;
    logic                   res_valid_reg, res_valid_next;
    ptp_res_t               res_reg,   res_next;

    logic               req_take;
    logic               out_free;
    logic               tick_start;
    logic [DELTA_W-1:0] delta_hold;
    ptp_tick_op_t       tick_op;
    ptp_tick_res_t      tick_res;

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign out_free  = !res_valid_reg || !res_stall;

    // register writes, indexes past the list are dropped
    always_comb
    begin
        speed_next    = speed_reg;
        target_x_next = target_x_reg;
        target_y_next = target_y_reg;
        scale_x_next  = scale_x_reg;
        scale_y_next  = scale_y_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SPEED:    speed_next    = cfg_data[SPEED_W-1:0];
                REG_TARGET_X: target_x_next = cfg_data;
                REG_TARGET_Y: target_y_next = cfg_data;
                REG_SCALE_X:  scale_x_next  = cfg_data[SCALE_W-1:0];
                REG_SCALE_Y:  scale_y_next  = cfg_data[SCALE_W-1:0];
                default:      speed_next    = speed_reg;
            endcase
        end
    end

    // magnitudes for the tick unit, from the registered signed distance
    assign tick_op.ax    = dx_reg[COORD_W] ? MAG_W'(-dx_reg) : MAG_W'(dx_reg);
    assign tick_op.ay    = dy_reg[COORD_W] ? MAG_W'(-dy_reg) : MAG_W'(dy_reg);
    assign tick_op.delta = delta_hold;

    assign tick_start = (state_reg == ST_PREP) && ((dx_reg != '0) || (dy_reg != '0));

    ptp_tick_unit u_tick (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tick_start),
        .op    (tick_op),
        .speed (speed_reg),
        .res   (tick_res)
    );

    // request sequencing
    always_comb
    begin
        state_next     = state_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        // a taken result frees the output register
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next = ST_DONE;
                    unique case (req.mode)
                        MODE_TICK:
                        begin
                            dx_next    = {target_x_reg[COORD_W-1], target_x_reg}
                                       - {cur_x_reg[COORD_W-1], cur_x_reg};
                            dy_next    = {target_y_reg[COORD_W-1], target_y_reg}
                                       - {cur_y_reg[COORD_W-1], cur_y_reg};
                            state_next = ST_PREP;
                        end
                        MODE_PLACE:
                        begin
                            cur_x_next = req.new_x;
                            cur_y_next = req.new_y;
                        end
                        MODE_CENTRE:
                        begin
                            // position such that the view centre lands on the point
                            cur_x_next = sat_coord({req.new_x[COORD_W-1], req.new_x}
                                                   - half_ext(scale_x_reg));
                            cur_y_next = sat_coord({req.new_y[COORD_W-1], req.new_y}
                                                   - half_ext(scale_y_reg));
                        end
                        default:
                        begin
                            // unused mode: position kept, result still returned
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PREP:
            begin
                // already on target: nothing to move
                state_next = tick_start ? ST_TICK : ST_DONE;
            end
            ST_TICK:
            begin
                if (tick_res.done)
                begin
                    if (tick_res.snap)
                    begin
                        cur_x_next = target_x_reg;
                        cur_y_next = target_y_reg;
                    end
                    else
                    begin
                        // the move never passes the target, so wraparound is exact
                        cur_x_next = dx_reg[COORD_W]
                                   ? cur_x_reg - coord_t'(tick_res.qx[COORD_W-1:0])
                                   : cur_x_reg + coord_t'(tick_res.qx[COORD_W-1:0]);
                        cur_y_next = dy_reg[COORD_W]
                                   ? cur_y_reg - coord_t'(tick_res.qy[COORD_W-1:0])
                                   : cur_y_reg + coord_t'(tick_res.qy[COORD_W-1:0]);
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_next.pos_x     = cur_x_reg;
                    res_next.pos_y     = cur_y_reg;
                    res_next.center_x  = sat_coord({cur_x_reg[COORD_W-1], cur_x_reg}
                                                   + half_ext(scale_x_reg));
                    res_next.center_y  = sat_coord({cur_y_reg[COORD_W-1], cur_y_reg}
                                                   + half_ext(scale_y_reg));
                    res_next.at_target = (cur_x_reg == target_x_reg)
                                      && (cur_y_reg == target_y_reg);
                    res_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg     <= '0;
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            scale_x_reg   <= '0;
            scale_y_reg   <= '0;
            state_reg     <= ST_IDLE;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            speed_reg     <= speed_next;
            target_x_reg  <= target_x_next;
            target_y_reg  <= target_y_next;
            scale_x_reg   <= scale_x_next;
            scale_y_reg   <= scale_y_next;
            state_reg     <= state_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        res_reg <= res_next;
        if (req_take)
        begin
            delta_hold <= req.delta;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    // the tick unit reports only while a tick request is waiting on it
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_res.done |-> (state_reg == ST_TICK))
        else $error("tick unit finished outside a tick request");

    // a move never goes farther than the distance to the target on either axis
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick_res.done && !tick_res.snap) |->
            ((tick_res.qx <= tick_op.ax) && (tick_res.qy <= tick_op.ay)))
        else $error("tick move overshoots the target");

    // landing on the target leaves the position equal to it
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK && tick_res.done && tick_res.snap) |=>
            ((cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg)))
        else $error("snap did not land on the target");
`endif

endmodule

// ===== sim/ptp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_checker
// Follows register writes and requests of the move stepper, predicts every
// result from its own copy of position and registers, and compares in order.
// ----------------------------------------------------------------------------
module ptp_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ptp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptp_pkg::COORD_W-1:0]   cfg_data,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  ptp_pkg::ptp_req_t             req,
    input  logic                          res_valid,
    input  logic                          res_stall,
    input  ptp_pkg::ptp_res_t             res,
    output int                            errors,
    output int                            pending,
    output int                            checked,
    output int                            snaps,
    output int                            moves
);
    import ptp_pkg::*;

    localparam logic [127:0] STEP_CAP = (128'd1 << STEP_W) - 1;

    logic [SPEED_W-1:0] speed;
    coord_t             tgt_x;
    coord_t             tgt_y;
    logic [SCALE_W-1:0] scl_x;
    logic [SCALE_W-1:0] scl_y;
    coord_t             cur_x;
    coord_t             cur_y;
    ptp_res_t           expected_q[$];
    int                 err_cnt  = 0;
    int                 chk_cnt  = 0;
    int                 snap_cnt = 0;
    int                 move_cnt = 0;

    task automatic report(input string msg);
        if (err_cnt < 40)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        err_cnt++;
    endtask

    task automatic check_field(input string name, input coord_t got, input coord_t want);
        if (got !== want)
        begin
            report($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    // clip a two-bit-wider signed value into the coordinate range
    function automatic coord_t clip(input logic signed [COORD_W+1:0] v);
        logic signed [COORD_W+1:0] top_v;
        logic signed [COORD_W+1:0] bot_v;
        top_v = {3'b000, {(COORD_W-1){1'b1}}};
        bot_v = {3'b111, {(COORD_W-1){1'b0}}};
        if (v > top_v)
            return top_v[COORD_W-1:0];
        if (v < bot_v)
            return bot_v[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    // p -/+ floor(scale/2), clipped
    function automatic coord_t shift_half(input coord_t p, input logic [SCALE_W-1:0] s,
                                          input logic down);
        logic signed [COORD_W+1:0] wp;
        logic signed [COORD_W+1:0] wh;
        wp = p;
        wh = '0;
        wh[SCALE_W-2:0] = s[SCALE_W-1:1];
        return clip(down ? wp - wh : wp + wh);
    endfunction

    // one tick: land on the target if it is within reach, else step along the line
    function automatic void move_toward(input logic [DELTA_W-1:0] dt);
        logic signed [COORD_W:0] dx;
        logic signed [COORD_W:0] dy;
        logic [PROD_W-1:0]       prod;
        logic [127:0]            ax, ay, stp, d2, root, trial, qx, qy;
        coord_t                  sx;
        coord_t                  sy;
        int                      b;
        dx = tgt_x - cur_x;
        dy = tgt_y - cur_y;
        if (dx == 0 && dy == 0)
            return;
        prod = PROD_W'(speed) * PROD_W'(dt);
        stp = '0;
        stp[PROD_W-FRAC_BITS-1:0] = prod[PROD_W-1:FRAC_BITS];
        if (stp > STEP_CAP)
            stp = STEP_CAP;
        ax = '0;
        ay = '0;
        ax[MAG_W-1:0] = dx[COORD_W] ? -dx : dx;
        ay[MAG_W-1:0] = dy[COORD_W] ? -dy : dy;
        d2 = ax * ax + ay * ay;
        if (d2 < stp * stp)
        begin
            cur_x = tgt_x;
            cur_y = tgt_y;
            snap_cnt++;
            return;
        end
        root = '0;
        for (b = STEP_W; b >= 0; b--)
        begin
            trial = root | (128'd1 << b);
            if (trial * trial <= d2)
                root = trial;
        end
        qx = (ax * stp) / root;
        qy = (ay * stp) / root;
        if (qx > ax)
            qx = ax;
        if (qy > ay)
            qy = ay;
        sx = qx[COORD_W-1:0];
        sy = qy[COORD_W-1:0];
        cur_x = dx[COORD_W] ? cur_x - sx : cur_x + sx;
        cur_y = dy[COORD_W] ? cur_y - sy : cur_y + sy;
        move_cnt++;
    endfunction

    function automatic ptp_res_t advance_position(input ptp_req_t r);
        ptp_res_t o;
        case (r.mode)
            MODE_TICK:
                move_toward(r.delta);
            MODE_PLACE:
            begin
                cur_x = r.new_x;
                cur_y = r.new_y;
            end
            MODE_CENTRE:
            begin
                cur_x = shift_half(r.new_x, scl_x, 1'b1);
                cur_y = shift_half(r.new_y, scl_y, 1'b1);
            end
            default:
                ;
        endcase
        o.pos_x     = cur_x;
        o.pos_y     = cur_y;
        o.center_x  = shift_half(cur_x, scl_x, 1'b0);
        o.center_y  = shift_half(cur_y, scl_y, 1'b0);
        o.at_target = (cur_x == tgt_x) && (cur_y == tgt_y);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        ptp_res_t want;
        if (!rst_n)
        begin
            speed = '0;
            tgt_x = '0;
            tgt_y = '0;
            scl_x = '0;
            scl_y = '0;
            cur_x = '0;
            cur_y = '0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SPEED:    speed = cfg_data[SPEED_W-1:0];
                    REG_TARGET_X: tgt_x = cfg_data;
                    REG_TARGET_Y: tgt_y = cfg_data;
                    REG_SCALE_X:  scl_x = cfg_data[SCALE_W-1:0];
                    REG_SCALE_Y:  scl_y = cfg_data[SCALE_W-1:0];
                    default:      ;
                endcase
            end
            if (res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    report($sformatf("result %h with nothing outstanding", res));
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("pos_x", res.pos_x, want.pos_x);
                    check_field("pos_y", res.pos_y, want.pos_y);
                    check_field("center_x", res.center_x, want.center_x);
                    check_field("center_y", res.center_y, want.center_y);
                    check_field("at_target", coord_t'(res.at_target),
                                coord_t'(want.at_target));
                    chk_cnt++;
                end
            end
            if (req_valid && !req_stall)
            begin
                expected_q.push_back(advance_position(req));
            end
        end
        errors  <= err_cnt;
        pending <= expected_q.size();
        checked <= chk_cnt;
        snaps   <= snap_cnt;
        moves   <= move_cnt;
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the point-to-point move stepper: a directed pass
// over extremes and corner cases, then random phases under fresh register
// settings, with random gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import ptp_pkg::*;

    // mode code the block leaves undefined: position must stay put
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 150;
    localparam int HOLD_AT       = 300;   // result count where the long hold-off starts
    localparam int HOLD_CYCLES   = 600;
    localparam int DRAIN_CYCLES  = 300;   // a little more than the longest tick

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;
    logic                 req_valid;
    logic                 req_stall;
    ptp_req_t             req;
    logic                 res_valid;
    logic                 res_stall;
    ptp_res_t             res;

    int errors;
    int pending;
    int checked;
    int snaps;
    int moves;

    int     sent        = 0;
    int     settings    = 0;
    bit     steady_send = 1'b0;   // phase where the sender never pauses
    coord_t aim_x;                // target as last programmed, for near-target placement
    coord_t aim_y;

    point_to_point_move_stepper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    ptp_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .snaps     (snaps),
        .moves     (moves)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // register writes: valid stays high across a burst, dropped at the end
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [COORD_W-1:0] spd, input coord_t tx,
                                input coord_t ty, input logic [COORD_W-1:0] sx,
                                input logic [COORD_W-1:0] sy);
        write_reg(REG_SPEED, spd);
        write_reg(REG_TARGET_X, tx);
        write_reg(REG_TARGET_Y, ty);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        // an index past the last register must change nothing
        write_reg(REG_SCALE_Y + CFG_IDX_W'($urandom_range(1, 3)), $urandom);
        cfg_valid <= 1'b0;
        aim_x = tx;
        aim_y = ty;
        settings++;
    endtask

    // ------------------------------------------------------------------
    // one request: optional gap, then hold the payload until it is taken
    // ------------------------------------------------------------------
    task automatic send_req(input ptp_req_t r);
        int gap;
        gap = steady_send ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sent++;
    endtask

    // stop offering, let every outstanding result come back, then settle
    task automatic wait_idle(input int extra);
        req_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (extra) @(posedge clk);
    endtask

    function automatic ptp_req_t make_req(input logic [MODE_W-1:0] m,
                                          input logic [DELTA_W-1:0] dt,
                                          input coord_t x, input coord_t y);
        ptp_req_t r;
        r.mode  = m;
        r.delta = dt;
        r.new_x = x;
        r.new_y = y;
        return r;
    endfunction

    // corners, origin, a small window around zero or anything at all
    function automatic coord_t pick_coord();
        case ($urandom_range(0, 5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return coord_t'($urandom_range(0, 32'h10_0000) - 32'h8_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_scale();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 32'h40_0000);
            default: return $urandom;
        endcase
    endfunction

    // a point around c, with an offset span drawn from 16 up to 2^28
    function automatic coord_t near_point(input coord_t c);
        int unsigned span;
        span = 32'd1 << (4 * $urandom_range(1, 7));
        return c + coord_t'($urandom_range(0, 2 * span) - span);
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall per result, quiet stretches, one long hold
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int hold;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        res_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            // long hold: the block parks a result and then stalls requests
            if (taken == HOLD_AT)
                hold = HOLD_CYCLES;
            else
                hold = calm ? 0 : $urandom_range(0, 14);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (!res_valid);
            taken++;
        end
    end

    // ------------------------------------------------------------------
    // main stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        ptp_req_t           r;
        logic [COORD_W-1:0] spd;
        int                 ph;
        int                 n;
        int                 sel;

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // top speed written with the spare upper bit set, target in opposite corners,
        // widest view in x and none in y
        program_regs(32'hFFFF_FFFF, COORD_MAX, COORD_MIN, 32'hFFFF_FFFF, 32'h0);
        send_req(make_req(MODE_TICK, '0, $urandom, $urandom));          // zero delta
        send_req(make_req(MODE_TICK, 20'd1, $urandom, $urandom));       // short step
        send_req(make_req(MODE_TICK, '1, $urandom, $urandom));          // clipped step, lands
        send_req(make_req(MODE_TICK, '1, $urandom, $urandom));          // already there
        send_req(make_req(MODE_PLACE, '1, COORD_MIN, COORD_MIN));       // delta unused
        send_req(make_req(MODE_TICK, 20'h0_8000, $urandom, $urandom));  // step along x only
        send_req(make_req(MODE_CENTRE, DELTA_W'($urandom), COORD_MIN, COORD_MAX)); // x clips low
        send_req(make_req(MODE_PLACE, DELTA_W'($urandom), COORD_MAX, COORD_MAX)); // centre high
        send_req(make_req(MODE_SPARE, DELTA_W'($urandom), $urandom, $urandom));
        send_req(make_req(MODE_PLACE, DELTA_W'($urandom), '0, '0));
        wait_idle(4);

        // no speed at all, widest view both ways
        program_regs('0, $urandom, $urandom, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_req(make_req(MODE_TICK, '1, $urandom, $urandom));
        send_req(make_req(MODE_CENTRE, DELTA_W'($urandom), COORD_MIN, COORD_MIN));
        send_req(make_req(MODE_PLACE, DELTA_W'($urandom), COORD_MAX, COORD_MIN));
        send_req(make_req(MODE_TICK, DELTA_W'($urandom), $urandom, $urandom));
        wait_idle(4);

        // slowest nonzero speed, small odd and even view sizes
        program_regs(32'd1, 32'h0001_0000, -32'sh0002_0000, 32'd3, 32'd2);
        send_req(make_req(MODE_PLACE, DELTA_W'($urandom), '0, '0));
        send_req(make_req(MODE_TICK, '1, $urandom, $urandom));          // step of 15
        send_req(make_req(MODE_TICK, 20'd1, $urandom, $urandom));       // step rounds to 0
        send_req(make_req(MODE_CENTRE, DELTA_W'($urandom), 32'sd1, 32'sd1)); // half scale floors
        send_req(make_req(MODE_SPARE, DELTA_W'($urandom), $urandom, $urandom));
        send_req(make_req(MODE_PLACE, DELTA_W'($urandom), 32'h0001_0000, -32'sh0002_0000));
        wait_idle(4);

        // random phases: mostly ticks, mixed with placements, many of them near the target,
        // so that both landing and straight-line steps can show up
        for (ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 9))
                0:          spd = '0;
                1, 2, 3:    spd = $urandom_range(1, 32'h1_0000);
                4, 5, 6:    spd = $urandom_range(0, 32'h100_0000);
                7, 8:       spd = $urandom;
                default:    spd = '1;
            endcase
            program_regs(spd, pick_coord(), pick_coord(), pick_scale(), pick_scale());
            steady_send = ($urandom_range(0, 3) == 0);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // fields a mode ignores still get random content
                r.delta = DELTA_W'($urandom);
                r.new_x = $urandom;
                r.new_y = $urandom;
                sel = $urandom_range(0, 99);
                if (sel < 60)
                begin
                    r.mode = MODE_TICK;
                    if ($urandom_range(0, 1) == 0)
                        r.delta = DELTA_W'($urandom_range(0, 4096));
                end
                else if (sel < 78)
                begin
                    r.mode = MODE_PLACE;
                    if ($urandom_range(0, 2) != 0)
                    begin
                        r.new_x = near_point(aim_x);
                        r.new_y = near_point(aim_y);
                    end
                end
                else if (sel < 94)
                begin
                    r.mode = MODE_CENTRE;
                    if ($urandom_range(0, 1) == 0)
                    begin
                        r.new_x = near_point(aim_x);
                        r.new_y = near_point(aim_y);
                    end
                end
                else
                begin
                    r.mode = MODE_SPARE;
                end
                send_req(r);
            end
            wait_idle(4);
        end
        steady_send = 1'b0;

        wait_idle(DRAIN_CYCLES);
        $display("run: %0d requests under %0d register settings, %0d results checked",
                 sent, settings, checked);
        $display("run: %0d ticks landed on the target, %0d stepped along the line",
                 snaps, moves);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hard stop, several times the slowest legal run
    initial
    begin : watchdog
        #25_000_000;
        $display("run: timed out with %0d results outstanding", pending);
        $display("tb: failure");
        $finish;
    end

endmodule
